// File: design/fup_pkg.sv
// Shared types, constants and helpers for the form body parser.
// Used by every module of the parser; depends on nothing.
package fup_pkg;

  localparam int BODY_LIMIT = 1024;
  localparam int BCNT_W     = $clog2(BODY_LIMIT);
  localparam int LEN_W      = 10;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [7:0] MAX_REC_RESET = 8'd16;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    EV_NAME_CHAR  = 3'd0,
    EV_VALUE_CHAR = 3'd1,
    EV_NAME_END   = 3'd2,
    EV_RECORD_END = 3'd3,
    EV_DONE       = 3'd4,
    EV_ERROR      = 3'd5
  } event_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       body_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       event_res;
    logic [7:0]       out_byte;
    logic [7:0]       record_index;
    logic [LEN_W-1:0] body_length;
    logic             run_last;
  } out_item_t;

  // One result without its run_last flag, which the back end adds.
  typedef struct packed {
    logic [2:0]       event_res;
    logic [7:0]       out_byte;
    logic [7:0]       record_index;
    logic [LEN_W-1:0] body_length;
  } result_t;

  // All results caused by one input item (count is 0 to 3; a bundle with count 0 is never queued).
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } bundle_t;

  typedef struct packed {
    logic    vld;
    bundle_t data;
  } q_port_t;

  // Hex digit value, or 16 when the byte is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41 + 8'd10);
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

endpackage

// File: design/fup_front.sv
// Front end of the form body parser: accepts bytes, keeps the parse state
// and turns each byte into a bundle of results. Depends on fup_pkg.
module fup_front import fup_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  input  logic      cfg_we,
  input  logic [7:0] cfg_data,
  output q_port_t   push
);

  typedef enum logic [1:0] {ESC_NONE, ESC_HIGH, ESC_LOW} esc_t;

  logic [7:0]        max_r;
  logic              inv_r, inv_nxt;
  logic              ns_r, ns_nxt;
  esc_t              esc_r, esc_nxt;
  logic [3:0]        hi_r, hi_nxt;
  logic [7:0]        rc_r, rc_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic              lim_r, lim_nxt;
  logic              fail_r, fail_nxt;

  logic              p_vld;
  result_t           p_res;
  logic [4:0]        hv;
  logic              bad;
  logic [1:0]        k;
  bundle_t           bnd;
  logic [7:0]        rc_done;

  always_comb begin
    inv_nxt  = inv_r;
    ns_nxt   = ns_r;
    esc_nxt  = esc_r;
    hi_nxt   = hi_r;
    rc_nxt   = rc_r;
    bcnt_nxt = bcnt_r;
    lim_nxt  = lim_r;
    fail_nxt = fail_r;
    p_vld    = 1'b0;
    p_res    = '0;
    hv       = hex_val(item.data_byte);
    bad      = 1'b0;
    k        = 2'd0;
    bnd      = '0;
    rc_done  = rc_r;

    if (!lim_r) begin
      if (bcnt_r == BCNT_W'(BODY_LIMIT - 1)) begin
        lim_nxt = 1'b1;
      end else begin
        bcnt_nxt = bcnt_r + 1'b1;
        if (!fail_r && rc_r < max_r) begin
          case (esc_r)
            ESC_HIGH: begin
              if (hv[4]) begin
                fail_nxt = 1'b1;
              end else begin
                hi_nxt  = hv[3:0];
                esc_nxt = ESC_LOW;
              end
            end
            ESC_LOW: begin
              if (hv[4]) begin
                fail_nxt = 1'b1;
              end else begin
                esc_nxt            = ESC_NONE;
                p_vld              = 1'b1;
                p_res.event_res    = inv_r ? EV_VALUE_CHAR : EV_NAME_CHAR;
                p_res.out_byte     = {hi_r, hv[3:0]};
                p_res.record_index = rc_r;
                if (!inv_r) ns_nxt = 1'b1;
              end
            end
            default: begin
              esc_nxt            = ESC_NONE;
              p_res.record_index = rc_r;
              if (item.data_byte == CH_EQ && !inv_r) begin
                p_vld           = 1'b1;
                p_res.event_res = EV_NAME_END;
                inv_nxt         = 1'b1;
              end else if (item.data_byte == CH_AMP && inv_r) begin
                p_vld           = 1'b1;
                p_res.event_res = EV_RECORD_END;
                rc_nxt          = rc_r + 1'b1;
                inv_nxt         = 1'b0;
                ns_nxt          = 1'b0;
              end else if (item.data_byte == CH_PCT) begin
                esc_nxt = ESC_HIGH;
                if (!inv_r) ns_nxt = 1'b1;
              end else begin
                p_vld           = 1'b1;
                p_res.event_res = inv_r ? EV_VALUE_CHAR : EV_NAME_CHAR;
                p_res.out_byte  = (item.data_byte == CH_PLUS) ? CH_SPACE : item.data_byte;
                if (!inv_r) ns_nxt = 1'b1;
              end
            end
          endcase
        end
      end
    end

    if (p_vld) begin
      bnd.res[0] = p_res;
      k          = 2'd1;
    end

    if (item.body_end) begin
      bad = fail_nxt || lim_nxt || esc_nxt == ESC_HIGH || esc_nxt == ESC_LOW ||
            (ns_nxt && !inv_nxt);
      rc_done = rc_nxt;
      if (bad) begin
        bnd.res[k].event_res    = EV_ERROR;
        bnd.res[k].record_index = rc_nxt;
        k                       = k + 2'd1;
      end else begin
        if (inv_nxt) begin
          bnd.res[k].event_res    = EV_RECORD_END;
          bnd.res[k].record_index = rc_nxt;
          k                       = k + 2'd1;
          rc_done                 = rc_nxt + 1'b1;
        end
        bnd.res[k].event_res    = EV_DONE;
        bnd.res[k].record_index = rc_done;
        bnd.res[k].body_length  = LEN_W'(bcnt_nxt);
        k                       = k + 2'd1;
      end
      inv_nxt  = 1'b0;
      ns_nxt   = 1'b0;
      esc_nxt  = ESC_NONE;
      hi_nxt   = '0;
      rc_nxt   = '0;
      bcnt_nxt = '0;
      lim_nxt  = 1'b0;
      fail_nxt = 1'b0;
    end
    bnd.count = k;
  end

  assign push.vld  = accept && (bnd.count != 2'd0);
  assign push.data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= MAX_REC_RESET;
      inv_r  <= 1'b0;
      ns_r   <= 1'b0;
      esc_r  <= ESC_NONE;
      hi_r   <= '0;
      rc_r   <= '0;
      bcnt_r <= '0;
      lim_r  <= 1'b0;
      fail_r <= 1'b0;
    end else begin
      if (cfg_we) max_r <= cfg_data;
      if (accept) begin
        inv_r  <= inv_nxt;
        ns_r   <= ns_nxt;
        esc_r  <= esc_nxt;
        hi_r   <= hi_nxt;
        rc_r   <= rc_nxt;
        bcnt_r <= bcnt_nxt;
        lim_r  <= lim_nxt;
        fail_r <= fail_nxt;
      end
    end
  end

endmodule

// File: design/fup_queue.sv
// Short bundle queue between the parser front end and the result sequencer.
// Depends on fup_pkg for the bundle type and depth.
module fup_queue import fup_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_port_t wr,
  output logic    full,
  input  logic    pop,
  output q_port_t rd
);

  bundle_t         mem [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt;
  logic [Q_AW-1:0] rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_pop;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign rd.vld  = (cnt_r != '0);
  assign rd.data = mem[rp_r];
  assign do_pop  = pop && rd.vld;

  always_comb begin
    wp_nxt  = wr.vld ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(wr.vld) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (wr.vld) mem[wp_r] <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: design/fup_back.sv
// Result sequencer: takes bundles from the queue and hands out their results
// one per cycle while out_stall is low, flagging the last one. Depends on fup_pkg.
module fup_back import fup_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_port_t   rd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  bundle_t    cur_r, cur_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic       last_slot;
  logic       advance;
  result_t    sel;

  assign last_slot = (idx_r == cur_r.count - 2'd1);
  assign advance   = vld_r && !out_stall;
  assign pop       = !vld_r || (advance && last_slot);
  assign sel       = cur_r.res[idx_r];

  always_comb begin
    cur_nxt = cur_r;
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (pop) begin
      cur_nxt = rd.data;
      idx_nxt = '0;
      vld_nxt = rd.vld;
    end else if (advance) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  assign out_valid             = vld_r;
  assign out_item.event_res    = sel.event_res;
  assign out_item.out_byte     = sel.out_byte;
  assign out_item.record_index = sel.record_index;
  assign out_item.body_length  = sel.body_length;
  assign out_item.run_last     = last_slot;

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

endmodule

// File: design/form_urlencoded_parser_core.sv
// Top level of the form body parser: front end, bundle queue and result
// sequencer. Depends on fup_pkg, fup_front, fup_queue and fup_back.

// The core takes an application/x-www-form-urlencoded body one byte per item
// and emits name characters, value characters, name ends, record ends and a
// closing done or error result, each with its record index. A byte is taken
// in every cycle while the four-entry bundle queue has room; the front end
// decodes a byte in the cycle it is accepted and stores all of its results
// as one bundle. The result sequencer hands out one result per cycle while
// out_stall is low; the final byte of a body can cause up to three results.
// Bytes that cause no result (a percent sign, the first hex digit of an
// escape, or bytes past the record limit) never reach the queue. The
// max_records register is written through cfg_we/cfg_data and should only
// be changed while no body is in flight. After the final byte the parse
// state returns to its reset values, ready for the next body.
module form_urlencoded_parser_core import fup_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  q_port_t q_wr;
  q_port_t q_rd;
  logic    q_full;
  logic    q_pop;
  logic    in_accept;

  // Stall depends only on queue occupancy, so the input side never waits
  // on the output handshake directly.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  fup_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .item     (in_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (q_wr)
  );

  fup_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .rd    (q_rd)
  );

  fup_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (q_rd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
